@@ rtl/core/skth_pkg.sv @@
// ----------------------------------------------------------------------------
// skth_pkg: shared types and constants for the top-half store
// Item layouts on both queues, the internal command format, field codes and
// sizing of the store and of the two small queues.
// ----------------------------------------------------------------------------
package skth_pkg;

    // Store sizing.
    localparam int CAPACITY = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Fixed field widths.
    localparam int KIND_W       = 2;
    localparam int VALUE_W      = 32;
    localparam int ITEM_COUNT_W = 6;
    localparam int STATUS_W     = 2;

    // Queue depths (powers of two, at least two).
    localparam int CQ_DEPTH = 2;
    localparam int OQ_DEPTH = 2;

    // Input kind codes.
    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TRIM   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    typedef enum logic [1:0] {
        OP_INSERT,
        OP_TRIM,
        OP_READ,
        OP_NOP
    } t_op;

    typedef struct packed {
        logic [KIND_W-1:0]         kind;
        logic signed [VALUE_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic signed [VALUE_W-1:0] item_value;
        logic [ITEM_COUNT_W-1:0]   item_count;
        logic [STATUS_W-1:0]       status;
        logic                      last;
    } t_out_item;

    typedef struct packed {
        t_op                       op;
        logic signed [VALUE_W-1:0] value;
    } t_cmd;

endpackage

@@ rtl/core/skth_front.sv @@
// ----------------------------------------------------------------------------
// skth_front: input decode and command queue
// Turns each accepted input transaction into a command and holds it in a
// short queue until the execution engine takes it.
// ----------------------------------------------------------------------------
module skth_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    input  skth_pkg::t_in_item i_item,
    output logic               full,
    output logic               o_cmd_valid,
    output skth_pkg::t_cmd     o_cmd,
    input  logic               i_cmd_take
);
    import skth_pkg::*;

    localparam int PTR_W = $clog2(CQ_DEPTH);
    localparam int QC_W  = $clog2(CQ_DEPTH + 1);

    t_cmd              r_q [CQ_DEPTH];
    logic [PTR_W-1:0]  r_wp;
    logic [PTR_W-1:0]  r_rp;
    logic [QC_W-1:0]   r_cnt;
    t_cmd              cmd_in;
    logic              wr;
    logic              rd;

    // Kind 3 has no meaning and becomes a no-op.
    always_comb begin
        cmd_in.value = i_item.value;
        unique case (i_item.kind)
            KIND_INSERT: cmd_in.op = OP_INSERT;
            KIND_TRIM:   cmd_in.op = OP_TRIM;
            KIND_READ:   cmd_in.op = OP_READ;
            default:     cmd_in.op = OP_NOP;
        endcase
    end

    assign full        = (r_cnt == QC_W'(CQ_DEPTH));
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rp];
    assign wr          = push && !full;
    assign rd          = o_cmd_valid && i_cmd_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) begin
                r_wp <= r_wp + 1'b1;
            end
            if (rd) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + QC_W'(wr) - QC_W'(rd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_q[r_wp] <= cmd_in;
        end
    end

endmodule

@@ rtl/core/skth_back.sv @@
// ----------------------------------------------------------------------------
// skth_back: execution engine with the value store
// Carries out insert, trim and read commands against a circular value store
// and produces result transactions for the output queue.
// ----------------------------------------------------------------------------
module skth_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cmd_valid,
    input  skth_pkg::t_cmd      i_cmd,
    output logic                o_cmd_take,
    output logic                o_res_push,
    output skth_pkg::t_out_item o_res,
    input  logic                i_res_full
);
    import skth_pkg::*;

    localparam logic [IDX_W:0] CAP_EXT = (IDX_W + 1)'(CAPACITY);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_SWAP_MAX,
        S_SWAP_OLD,
        S_RESP,
        S_RD_ADDR,
        S_RD_DATA
    } t_state;

    // List position to store address; the front of the list sits at the head.
    function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] head,
                                              input logic [IDX_W-1:0] idx);
        logic [IDX_W:0] sum;
        sum = {1'b0, head} + {1'b0, idx};
        if (sum >= CAP_EXT) begin
            sum = sum - CAP_EXT;
        end
        return sum[IDX_W-1:0];
    endfunction

    logic [VALUE_W-1:0]         mem [CAPACITY];

    t_state                     r_state, n_state;
    logic [IDX_W-1:0]           r_head, n_head;
    logic [CNT_W-1:0]           r_count, n_count;
    logic [STATUS_W-1:0]        r_status, n_status;
    logic [CNT_W-1:0]           r_half, n_half;
    logic [IDX_W-1:0]           r_p, n_p;
    logic [IDX_W-1:0]           r_j, n_j;
    logic                       r_rv, n_rv;
    logic [IDX_W-1:0]           r_ridx, n_ridx;
    logic signed [VALUE_W-1:0]  r_max, n_max;
    logic [IDX_W-1:0]           r_maxi, n_maxi;
    logic signed [VALUE_W-1:0]  r_pval, n_pval;
    logic signed [VALUE_W-1:0]  r_rdata;

    logic                       mem_we;
    logic [IDX_W-1:0]           mem_waddr;
    logic [VALUE_W-1:0]         mem_wdata;
    logic                       mem_re;
    logic [IDX_W-1:0]           mem_raddr;
    logic [IDX_W-1:0]           head_dec;
    logic                       j_is_last;

    assign head_dec  = (r_head == '0) ? IDX_W'(CAPACITY - 1) : r_head - 1'b1;
    assign j_is_last = (CNT_W'(r_j) == r_count - CNT_W'(1));

    always_comb begin
        n_state    = r_state;
        n_head     = r_head;
        n_count    = r_count;
        n_status   = r_status;
        n_half     = r_half;
        n_p        = r_p;
        n_j        = r_j;
        n_rv       = 1'b0;
        n_ridx     = r_ridx;
        n_max      = r_max;
        n_maxi     = r_maxi;
        n_pval     = r_pval;
        o_cmd_take = 1'b0;
        o_res_push = 1'b0;
        o_res      = '0;
        mem_we     = 1'b0;
        mem_waddr  = '0;
        mem_wdata  = '0;
        mem_re     = 1'b0;
        mem_raddr  = '0;

        // Max search over the read stream; the first word of a pass is the
        // current position itself and seeds the search.
        if (r_rv) begin
            if (r_ridx == r_p) begin
                n_max  = r_rdata;
                n_maxi = r_p;
                n_pval = r_rdata;
            end else if (r_rdata > r_max) begin
                n_max  = r_rdata;
                n_maxi = r_ridx;
            end
        end

        unique case (r_state)
            S_IDLE: begin
                o_cmd_take = 1'b1;
                if (i_cmd_valid) begin
                    unique case (i_cmd.op)
                        OP_INSERT: begin
                            if (r_count == CNT_W'(CAPACITY)) begin
                                n_status = ST_FULL;
                            end else begin
                                mem_we    = 1'b1;
                                mem_waddr = head_dec;
                                mem_wdata = i_cmd.value;
                                n_head    = head_dec;
                                n_count   = r_count + 1'b1;
                                n_status  = ST_OK;
                            end
                            n_state = S_RESP;
                        end
                        OP_TRIM: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                                n_state  = S_RESP;
                            end else if (r_count == CNT_W'(1)) begin
                                n_status = ST_OK;
                                n_state  = S_RESP;
                            end else begin
                                n_half  = r_count >> 1;
                                n_p     = '0;
                                n_j     = '0;
                                n_state = S_SCAN;
                            end
                        end
                        OP_READ: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                                n_state  = S_RESP;
                            end else begin
                                n_j     = '0;
                                n_state = S_RD_ADDR;
                            end
                        end
                        default: begin
                            n_status = ST_OK;
                            n_state  = S_RESP;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                mem_re    = 1'b1;
                mem_raddr = phys(r_head, r_j);
                n_rv      = 1'b1;
                n_ridx    = r_j;
                if (j_is_last) begin
                    n_state = S_DRAIN;
                end else begin
                    n_j = r_j + 1'b1;
                end
            end
            S_DRAIN: begin
                n_state = S_SWAP_MAX;
            end
            S_SWAP_MAX: begin
                mem_we    = 1'b1;
                mem_waddr = phys(r_head, r_p);
                mem_wdata = r_max;
                n_state   = S_SWAP_OLD;
            end
            S_SWAP_OLD: begin
                mem_we    = 1'b1;
                mem_waddr = phys(r_head, r_maxi);
                mem_wdata = r_pval;
                if (CNT_W'(r_p) + CNT_W'(1) == r_half) begin
                    n_count  = r_half;
                    n_status = ST_OK;
                    n_state  = S_RESP;
                end else begin
                    n_p     = r_p + 1'b1;
                    n_j     = r_p + 1'b1;
                    n_state = S_SCAN;
                end
            end
            S_RESP: begin
                o_res_push       = 1'b1;
                o_res.item_value = '0;
                o_res.item_count = ITEM_COUNT_W'(r_count);
                o_res.status     = r_status;
                o_res.last       = 1'b1;
                if (!i_res_full) begin
                    n_state = S_IDLE;
                end
            end
            S_RD_ADDR: begin
                mem_re    = 1'b1;
                mem_raddr = phys(r_head, r_j);
                n_state   = S_RD_DATA;
            end
            S_RD_DATA: begin
                o_res_push       = 1'b1;
                o_res.item_value = r_rdata;
                o_res.item_count = ITEM_COUNT_W'(r_count);
                o_res.status     = ST_OK;
                o_res.last       = j_is_last;
                if (!i_res_full) begin
                    if (j_is_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_j     = r_j + 1'b1;
                        n_state = S_RD_ADDR;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_head   <= '0;
            r_count  <= '0;
            r_status <= ST_OK;
            r_rv     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_count  <= n_count;
            r_status <= n_status;
            r_rv     <= n_rv;
        end
        r_half <= n_half;
        r_p    <= n_p;
        r_j    <= n_j;
        r_ridx <= n_ridx;
        r_max  <= n_max;
        r_maxi <= n_maxi;
        r_pval <= n_pval;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= mem[mem_raddr];
        end
    end

endmodule

@@ rtl/core/skth_outq.sv @@
// ----------------------------------------------------------------------------
// skth_outq: result queue
// Holds finished result transactions so the engine can keep working while
// the receiver stalls.
// ----------------------------------------------------------------------------
module skth_outq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  skth_pkg::t_out_item i_item,
    output logic                o_full,
    output logic                empty,
    input  logic                pop,
    output skth_pkg::t_out_item o_item
);
    import skth_pkg::*;

    localparam int PTR_W = $clog2(OQ_DEPTH);
    localparam int QC_W  = $clog2(OQ_DEPTH + 1);

    t_out_item        r_q [OQ_DEPTH];
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [QC_W-1:0]  r_cnt;
    logic             wr;
    logic             rd;

    assign o_full = (r_cnt == QC_W'(OQ_DEPTH));
    assign empty  = (r_cnt == '0);
    assign o_item = r_q[r_rp];
    assign wr     = i_push && !o_full;
    assign rd     = pop && !empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) begin
                r_wp <= r_wp + 1'b1;
            end
            if (rd) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + QC_W'(wr) - QC_W'(rd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_q[r_wp] <= i_item;
        end
    end

endmodule

@@ rtl/core/set_keep_top_half_top.sv @@
// ----------------------------------------------------------------------------
// set_keep_top_half_top: bounded value store with trim to the top half
// Both sides look like queues. An input transaction is taken when push is
// high and full is low; a result transaction is taken when pop is high and
// empty is low, and the oldest result sits on o_result while empty is low.
// Insert puts a value at the front of the list (status full when the store
// is at capacity), trim sorts descending and keeps the largest half, rounded
// down, with a single value kept as it is; read returns every stored value
// front first with last set on the final one. Insert, trim of zero or one
// value and unused kinds go from the idle state straight to a single
// result. A read issues one store read per value and gives its result
// once the data is back. A trim of n values runs a max search per kept
// position over the single read port of the store. Commands run one at a
// time in the engine; a two-entry command queue takes further input
// meanwhile. Reset clears the queues, the count and the engine state; the
// value store itself is not cleared, since only written entries are ever
// read. When the receiver stalls, the result queue fills and the engine
// waits on it, then the command queue fills and full rises.
// ----------------------------------------------------------------------------
module set_keep_top_half_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    input  skth_pkg::t_in_item  i_item,
    output logic                full,
    output logic                empty,
    input  logic                pop,
    output skth_pkg::t_out_item o_result
);
    import skth_pkg::*;

    // Command channel from the decoder to the engine.
    logic      cmd_valid;
    t_cmd      cmd;
    logic      cmd_take;

    // Result channel from the engine to the output queue.
    logic      res_push;
    t_out_item res;
    logic      res_full;

    // Front: decodes the kind and buffers the command.
    skth_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .i_item      (i_item),
        .full        (full),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_take  (cmd_take)
    );

    // Back: owns the store and executes one command at a time.
    skth_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_take  (cmd_take),
        .o_res_push  (res_push),
        .o_res       (res),
        .i_res_full  (res_full)
    );

    // Result queue decouples the engine from a stalling receiver.
    skth_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_item  (res),
        .o_full  (res_full),
        .empty   (empty),
        .pop     (pop),
        .o_item  (o_result)
    );

endmodule

@@ rtl/core/skth_checker.sv @@
// ----------------------------------------------------------------------------
// skth_checker: port-level checks for the top-half store
// Watches the queue ports of the top level and checks reset behavior and the
// consistency of status, count and last on result transactions.
// ----------------------------------------------------------------------------
module skth_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                full,
    input logic                empty,
    input logic                pop,
    input skth_pkg::t_out_item o_result
);
    import skth_pkg::*;

    // Reset leaves no result waiting and room for input.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("queues not cleared by reset");

    // A waiting result that is not taken stays put.
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_result))
        else $error("stalled result changed");

    // A dropped insert reports a full store as a single result.
    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_result.status == ST_FULL |->
            o_result.item_count == ITEM_COUNT_W'(CAPACITY) && o_result.last &&
            o_result.item_value == '0)
        else $error("full status with inconsistent fields");

    // Empty status always means a zero count and a single result.
    a_empty_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_result.status == ST_EMPTY |->
            o_result.item_count == '0 && o_result.last &&
            o_result.item_value == '0)
        else $error("empty status with inconsistent fields");

    // Only a read of a non-empty store gives results without last.
    a_multi_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !o_result.last |->
            o_result.status == ST_OK && o_result.item_count != '0)
        else $error("non-final result outside a read");

endmodule

bind set_keep_top_half_top skth_checker u_skth_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .full     (full),
    .empty    (empty),
    .pop      (pop),
    .o_result (o_result)
);
